>>> hdl/poq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poq_pkg
// Shared field widths, command and status codes, and the stored entry type
// of the page order queue.
// ----------------------------------------------------------------------------
package poq_pkg;

  localparam int CMD_W  = 2;
  localparam int TIX_W  = 16;
  localparam int VPG_W  = 20;
  localparam int FRM_W  = 16;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_OCC = 2'd2;

  typedef struct packed {
    logic [TIX_W-1:0] table_index;
    logic [VPG_W-1:0] virtual_page;
    logic [FRM_W-1:0] frame;
    logic             referenced;
  } entry_t;

endpackage

>>> hdl/poq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poq_if
// Valid/ready channels of the page order queue: command words in, result
// words out.
// ----------------------------------------------------------------------------
interface poq_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [poq_pkg::CMD_W-1:0]  cmd;
  logic [poq_pkg::TIX_W-1:0]  table_index;
  logic [poq_pkg::VPG_W-1:0]  virtual_page;
  logic [poq_pkg::FRM_W-1:0]  frame;
  logic                       ref_bit;
  logic [poq_pkg::POS_W-1:0]  position;

  modport source (output valid, cmd, table_index, virtual_page, frame, ref_bit, position,
                  input ready);
  modport sink (input valid, cmd, table_index, virtual_page, frame, ref_bit, position,
                output ready);
endinterface

interface poq_res_if;
  logic                       valid;
  logic                       ready;
  logic [poq_pkg::STAT_W-1:0] status;
  logic [poq_pkg::FRM_W-1:0]  removed_frame;
  logic [poq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, status, removed_frame, occupancy, input ready);
  modport sink (input valid, status, removed_frame, occupancy, output ready);
endinterface

>>> hdl/page_order_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_order_queue_core
// Ordered queue of resident pages for FIFO or second-chance replacement,
// held in one synchronous memory with a shift engine that closes gaps.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered by exactly one result
// word. Insert, a rejected command and the unused command code go from idle
// through done to the result register. Move and remove of the entry at
// position p go through load, any shift, tail and done: the entries above p
// are copied down one per cycle through the single read/write port pair of
// the entry memory, so a full queue of QUEUE_DEPTH entries gives the longest
// command. A new command word is accepted while the last result still waits.
module page_order_queue_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  poq_cmd_if.sink        req,
  poq_res_if.source      rsp
);
  import poq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = CW + 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     idx, idx_next;
  logic [CMD_W-1:0]  op, op_next;
  logic              ref_q, ref_next;
  entry_t            moving, moving_next;
  logic [STAT_W-1:0] stat, stat_next;
  logic [FRM_W-1:0]  rm, rm_next;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [FRM_W-1:0]  out_frame;
  logic [OCC_W-1:0]  out_occ;

  logic              we;
  logic [AW-1:0]     wa, ra;
  entry_t            wd;

  logic              accept, out_load;
  logic [PW-1:0]     pos_ext;
  logic              pos_ok, full;
  logic [XW-1:0]     idx_x, cnt_x;
  logic [CW-1:0]     cnt_m1;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign pos_ext = PW'(req.position);
  assign pos_ok  = pos_ext < PW'(count);
  assign full    = count >= CW'(QUEUE_DEPTH);
  assign idx_x   = XW'(idx);
  assign cnt_x   = XW'(count);
  assign cnt_m1  = count - CW'(1);

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    op_next     = op;
    ref_next    = ref_q;
    moving_next = moving;
    stat_next   = stat;
    rm_next     = rm;
    we          = 1'b0;
    wa          = count[AW-1:0];
    wd          = '{table_index: req.table_index, virtual_page: req.virtual_page,
                    frame: req.frame, referenced: req.ref_bit};
    ra          = idx;
    case (state)
      S_IDLE: begin
        ra = pos_ext[AW-1:0];
        if (accept) begin
          op_next   = req.cmd;
          ref_next  = req.ref_bit;
          idx_next  = pos_ext[AW-1:0];
          stat_next = STAT_DONE;
          rm_next   = '0;
          state_next = S_DONE;
          case (req.cmd)
            CMD_INSERT: begin
              if (full) begin
                stat_next = STAT_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            CMD_MOVE, CMD_REMOVE: begin
              if (!pos_ok) begin
                stat_next = STAT_NOT_OCC;
              end else begin
                state_next = S_LOAD;
              end
            end
            default: begin
              stat_next = STAT_DONE;
            end
          endcase
        end
      end
      S_LOAD: begin
        moving_next = rd_q;
        ra          = idx + AW'(1);
        if (idx_x + XW'(1) < cnt_x) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_SHIFT: begin
        we       = 1'b1;
        wa       = idx;
        wd       = rd_q;
        idx_next = idx + AW'(1);
        ra       = idx + AW'(2);
        if (!(idx_x + XW'(2) < cnt_x)) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        // moved entry lands at the tail, removed one drops the count
        if (op == CMD_MOVE) begin
          we = 1'b1;
          wa = cnt_m1[AW-1:0];
          wd = '{table_index: moving.table_index, virtual_page: moving.virtual_page,
                 frame: moving.frame, referenced: ref_q};
        end else begin
          count_next = cnt_m1;
          rm_next    = moving.frame;
        end
        stat_next  = STAT_DONE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    op     <= op_next;
    ref_q  <= ref_next;
    moving <= moving_next;
    stat   <= stat_next;
    rm     <= rm_next;
    if (out_load) begin
      out_status <= stat;
      out_frame  <= rm;
      out_occ    <= OCC_W'(count);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_frame = out_frame;
  assign rsp.occupancy     = out_occ;

endmodule
